// ===== rtl/xpbm_pkg.sv =====
package xpbm_pkg;

    // Widths of the payload fields
    localparam int CMD_W    = 2;
    localparam int VEC_W    = 3;
    localparam int WIDX_W   = 4;
    localparam int WORD_W   = 32;
    localparam int DOT_W    = 11;

    // Configuration register widths and indexes
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int ROWS_REG_W  = 4;
    localparam int COLS_REG_W  = 4;
    localparam int WORDS_REG_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS = 2'd2;

    localparam logic [ROWS_REG_W-1:0]  ROWS_RESET  = 4'd8;
    localparam logic [COLS_REG_W-1:0]  COLS_RESET  = 4'd8;
    localparam logic [WORDS_REG_W-1:0] WORDS_RESET = 5'd16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // At most this many results per compute run
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;

    localparam int BITS_PER_WORD = 32;
    localparam int DOT_MAX = 1023;
    localparam int DOT_MIN = -1024;

    // Index widths carried between controller and datapath, sized for the
    // largest supported store geometry
    localparam int ROW_IDX_W  = 6;
    localparam int COL_IDX_W  = 6;
    localparam int WORD_IDX_W = 8;
    localparam int NWORDS_W   = 9;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [VEC_W-1:0]  vector_index;
        logic [WIDX_W-1:0] word_index;
        logic [WORD_W-1:0] word_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot_value;
        logic [VEC_W-1:0]        result_row;
        logic [VEC_W-1:0]        result_col;
        logic                    last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  wr_a;
        logic                  wr_b;
        logic                  rd_en;
        logic                  acc_clr;
        logic                  emit;
        logic                  last;
        logic [ROW_IDX_W-1:0]  row;
        logic [COL_IDX_W-1:0]  col;
        logic [WORD_IDX_W-1:0] word;
        logic [NWORDS_W-1:0]   nwords;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/xnor_popcount_binary_matmul.sv =====
// Binary (+1/-1) matrix multiply on bit-packed words. Load transactions write one
// 32-bit word of an A row (cmd 0) or a B column (cmd 1). A compute transaction
// (cmd 2) emits one result per (row, column) pair in use, rows outer, columns inner,
// at most 64, the final one flagged with last; each result is 32*words -
// 2*popcount(a^b) summed over the words in use. Each word pair is read from the two
// single-port stores and popcounted one per cycle (no reads when words_in_use is 0),
// then the result waits for a free output register. The block takes no new input
// until a compute run has handed its last result to the output register.
// Store entries must be written before a compute reads them.
module xnor_popcount_binary_matmul
    import xpbm_pkg::*;
#(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int MAX_WORDS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    xpbm_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_WORDS (MAX_WORDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_in_data.cmd),
        .o_in_ready  (o_in_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    xpbm_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_WORDS (MAX_WORDS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/xpbm_ctrl.sv =====
module xpbm_ctrl
    import xpbm_pkg::*;
#(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int MAX_WORDS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [CMD_W-1:0]      i_cmd,
    output logic                  o_in_ready,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_sts               i_sts,
    output t_dp_cmd               o_cmd
);

    localparam int RW  = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1;
    localparam int CW  = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1;
    localparam int WW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int NWW = $clog2(MAX_WORDS + 1);

    t_state r_state, n_state;
    logic [ROWS_REG_W-1:0]  r_rows;
    logic [COLS_REG_W-1:0]  r_cols;
    logic [WORDS_REG_W-1:0] r_words;
    logic [RW-1:0]    r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [WW-1:0]    r_word, n_word;
    logic [CNT_W-1:0] r_count, n_count;

    logic [NRW-1:0] nr;
    logic [NCW-1:0] nc;
    logic [NWW-1:0] nw;
    logic last_row, last_col, last_word, last_res;

    // Register values above the store geometry saturate
    assign nr = (32'(r_rows)  > MAX_ROWS)  ? NRW'(MAX_ROWS)  : NRW'(r_rows);
    assign nc = (32'(r_cols)  > MAX_COLS)  ? NCW'(MAX_COLS)  : NCW'(r_cols);
    assign nw = (32'(r_words) > MAX_WORDS) ? NWW'(MAX_WORDS) : NWW'(r_words);

    assign last_row  = (32'(r_row)  + 1) == 32'(nr);
    assign last_col  = (32'(r_col)  + 1) == 32'(nc);
    assign last_word = (32'(r_word) + 1) == 32'(nw);
    assign last_res  = (last_row && last_col) || (32'(r_count) == RESULT_CAP - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= ROWS_RESET;
            r_cols  <= COLS_RESET;
            r_words <= WORDS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS:  r_rows  <= i_cfg_data[ROWS_REG_W-1:0];
                CFG_COLS:  r_cols  <= i_cfg_data[COLS_REG_W-1:0];
                CFG_WORDS: r_words <= i_cfg_data[WORDS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_word  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_word  <= n_word;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_word  = r_word;
        n_count = r_count;
        o_in_ready = 1'b0;

        o_cmd         = '0;
        o_cmd.row     = ROW_IDX_W'(r_row);
        o_cmd.col     = COL_IDX_W'(r_col);
        o_cmd.word    = WORD_IDX_W'(r_word);
        o_cmd.nwords  = NWORDS_W'(nw);
        o_cmd.last    = last_res;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_WR_A: o_cmd.wr_a = 1'b1;
                        CMD_WR_B: o_cmd.wr_b = 1'b1;
                        CMD_COMPUTE: begin
                            if (nr != '0 && nc != '0) begin
                                o_cmd.acc_clr = 1'b1;
                                n_row   = '0;
                                n_col   = '0;
                                n_word  = '0;
                                n_count = '0;
                                n_state = (nw == '0) ? S_EMIT : S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                if (last_word) begin
                    n_word  = '0;
                    n_state = S_WAIT;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            // last word's popcount lands in the accumulator here
            S_WAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.acc_clr = 1'b1;
                    if (last_res) begin
                        n_state = S_IDLE;
                    end else begin
                        n_count = r_count + 1'b1;
                        if (last_col) begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                        n_state = (nw == '0) ? S_EMIT : S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last) |=> (r_state == S_IDLE))
        else $error("run continued after last result");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) < RESULT_CAP)
        else $error("result count beyond cap");

    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (32'(r_word) < 32'(nw)))
        else $error("word read beyond words in use");

endmodule

// ===== rtl/xpbm_datapath.sv =====
module xpbm_datapath
    import xpbm_pkg::*;
#(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 8,
    parameter int MAX_WORDS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int A_DEPTH = MAX_ROWS * MAX_WORDS;
    localparam int B_DEPTH = MAX_COLS * MAX_WORDS;
    localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int BAW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int MW  = $clog2(BITS_PER_WORD * MAX_WORDS + 1);
    localparam int DW  = MW + 2;

    logic [WORD_W-1:0] mem_a [A_DEPTH];
    logic [WORD_W-1:0] mem_b [B_DEPTH];

    logic [WORD_W-1:0] r_a_q, r_b_q;
    logic              r_rd_vld;
    logic [MW-1:0]     r_miss;
    t_out_item         r_out;
    logic              r_out_vld;

    logic [AAW-1:0] wa_addr, ra_addr;
    logic [BAW-1:0] wb_addr, rb_addr;
    logic [5:0]     pop;
    logic signed [DW-1:0] dot;
    logic signed [31:0]   dot32;
    logic signed [DOT_W-1:0] dot_sat;

    assign wa_addr = AAW'(32'(i_item.vector_index) * MAX_WORDS + 32'(i_item.word_index));
    assign wb_addr = BAW'(32'(i_item.vector_index) * MAX_WORDS + 32'(i_item.word_index));
    assign ra_addr = AAW'(32'(i_cmd.row) * MAX_WORDS + 32'(i_cmd.word));
    assign rb_addr = BAW'(32'(i_cmd.col) * MAX_WORDS + 32'(i_cmd.word));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && (32'(i_item.vector_index) < MAX_ROWS) &&
            (32'(i_item.word_index) < MAX_WORDS)) begin
            mem_a[wa_addr] <= i_item.word_value;
        end
        if (i_cmd.rd_en) begin
            r_a_q <= mem_a[ra_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b && (32'(i_item.vector_index) < MAX_COLS) &&
            (32'(i_item.word_index) < MAX_WORDS)) begin
            mem_b[wb_addr] <= i_item.word_value;
        end
        if (i_cmd.rd_en) begin
            r_b_q <= mem_b[rb_addr];
        end
    end

    assign pop = 6'($countones(r_a_q ^ r_b_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_miss <= '0;
        end else if (r_rd_vld) begin
            r_miss <= r_miss + MW'(pop);
        end
    end

    // 32 * words - 2 * mismatches, saturated to the output width
    always_comb begin
        dot   = (DW'(i_cmd.nwords) <<< 5) - (DW'(r_miss) <<< 1);
        dot32 = 32'(dot);
        if (dot32 > DOT_MAX) begin
            dot_sat = DOT_W'(DOT_MAX);
        end else if (dot32 < DOT_MIN) begin
            dot_sat = DOT_W'(DOT_MIN);
        end else begin
            dot_sat = dot32[DOT_W-1:0];
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.dot_value  <= dot_sat;
            r_out.result_row <= VEC_W'(i_cmd.row);
            r_out.result_col <= VEC_W'(i_cmd.col);
            r_out.last       <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> (r_out_vld && $stable(r_out)))
        else $error("pending result overwritten");

    a_rd_not_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rd_vld && i_cmd.emit))
        else $error("result emitted while accumulation pending");

    a_one_store_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_a && i_cmd.wr_b))
        else $error("both stores written in one cycle");

endmodule
